[src/lcdt_pkg.sv]
package lcdt_pkg;

  // Line timing in dots
  localparam logic [8:0] LINE_DOTS   = 9'd456;
  localparam logic [8:0] DOTS_OAM    = 9'd80;
  localparam logic [8:0] DOTS_DRAW   = 9'd172;
  localparam logic [8:0] DOTS_HBLANK = 9'd204;

  // Line numbers
  localparam logic [7:0] LAST_LINE         = 8'd153;
  localparam logic [7:0] LAST_VISIBLE_LINE = 8'd143;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LCD_ENABLE     = 3'd0,
    REG_WIN_ENABLE     = 3'd1,
    REG_WINDOW_LINE    = 3'd2,
    REG_COMPARE_LINE   = 3'd3,
    REG_HBLANK_IRQ_EN  = 3'd4,
    REG_VBLANK_IRQ_EN  = 3'd5,
    REG_OAM_IRQ_EN     = 3'd6,
    REG_COMPARE_IRQ_EN = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic       lcd_enable;
    logic       win_enable;
    logic [7:0] window_line;
    logic [7:0] compare_line;
    logic       hblank_irq_en;
    logic       vblank_irq_en;
    logic       oam_irq_en;
    logic       compare_irq_en;
  } cfg_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic       pad;
    logic       window_armed;
    logic       render_line;
    logic       vblank_irq;
    logic       lcd_irq;
    logic       coincidence;
    logic [7:0] line;
    logic [1:0] mode;
  } result_t;

endpackage

[src/lcdt_cfg_regs.sv]
module lcdt_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lcdt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lcdt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output lcdt_pkg::cfg_t                  cfg_o
);
  import lcdt_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LCD_ENABLE:     cfg_d.lcd_enable     = cfg_data_i[0];
        REG_WIN_ENABLE:     cfg_d.win_enable     = cfg_data_i[0];
        REG_WINDOW_LINE:    cfg_d.window_line    = cfg_data_i;
        REG_COMPARE_LINE:   cfg_d.compare_line   = cfg_data_i;
        REG_HBLANK_IRQ_EN:  cfg_d.hblank_irq_en  = cfg_data_i[0];
        REG_VBLANK_IRQ_EN:  cfg_d.vblank_irq_en  = cfg_data_i[0];
        REG_OAM_IRQ_EN:     cfg_d.oam_irq_en     = cfg_data_i[0];
        REG_COMPARE_IRQ_EN: cfg_d.compare_irq_en = cfg_data_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{lcd_enable:     1'b1,
                 win_enable:     1'b0,
                 window_line:    8'd0,
                 compare_line:   8'd0,
                 hblank_irq_en:  1'b0,
                 vblank_irq_en:  1'b0,
                 oam_irq_en:     1'b0,
                 compare_irq_en: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[src/lcdt_timing.sv]
module lcdt_timing (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             tick_i,
  input  lcdt_pkg::cfg_t   cfg_i,
  output lcdt_pkg::result_t result_o
);
  import lcdt_pkg::*;

  logic [8:0] dot_q, dot_d;
  mode_e      mode_q, mode_d;
  logic [7:0] line_q, line_d;
  logic       coin_q, coin_d;
  logic       win_q, win_d;

  logic [8:0] dot_inc;
  logic [8:0] line_next9;
  logic       lcd_irq, vblank_irq, render;
  logic       line_chg;

  assign dot_inc    = dot_q + 9'd1;
  assign line_next9 = {1'b0, line_q} + 9'd1;

  always_comb begin
    dot_d      = dot_q;
    mode_d     = mode_q;
    line_d     = line_q;
    coin_d     = coin_q;
    win_d      = win_q;
    lcd_irq    = 1'b0;
    vblank_irq = 1'b0;
    render     = 1'b0;
    line_chg   = 1'b0;
    if (!cfg_i.lcd_enable) begin
      dot_d  = '0;
      line_d = '0;
      mode_d = MODE_OAM;
    end else if (tick_i) begin
      dot_d = dot_inc;
      unique case (mode_q)
        MODE_OAM: begin
          if (dot_inc >= DOTS_OAM) begin
            dot_d  = dot_inc - DOTS_OAM;
            mode_d = MODE_DRAW;
          end
        end
        MODE_DRAW: begin
          if (dot_inc >= DOTS_DRAW) begin
            dot_d   = dot_inc - DOTS_DRAW;
            mode_d  = MODE_HBLANK;
            lcd_irq = cfg_i.hblank_irq_en;
            render  = (line_q <= LAST_VISIBLE_LINE);
          end
        end
        MODE_HBLANK: begin
          if (dot_inc >= DOTS_HBLANK) begin
            dot_d    = dot_inc - DOTS_HBLANK;
            line_d   = line_next9[7:0];
            line_chg = 1'b1;
            if (line_q != LAST_VISIBLE_LINE) begin
              mode_d  = MODE_OAM;
              lcd_irq = cfg_i.oam_irq_en;
              if (cfg_i.win_enable && (line_next9 == {1'b0, cfg_i.window_line})) begin
                win_d = 1'b1;
              end
            end else begin
              mode_d     = MODE_VBLANK;
              lcd_irq    = cfg_i.vblank_irq_en;
              vblank_irq = 1'b1;
              win_d      = 1'b0;
            end
          end
        end
        MODE_VBLANK: begin
          if (dot_inc >= LINE_DOTS) begin
            dot_d    = dot_inc - LINE_DOTS;
            line_chg = 1'b1;
            if (line_q == LAST_LINE) begin
              line_d  = '0;
              mode_d  = MODE_OAM;
              lcd_irq = cfg_i.oam_irq_en;
            end else begin
              line_d = line_next9[7:0];
            end
          end
        end
        default: begin
          dot_d = dot_inc;
        end
      endcase
      // compare on every line change
      if (line_chg) begin
        coin_d = (line_d == cfg_i.compare_line);
        if (coin_d && cfg_i.compare_irq_en) begin
          lcd_irq = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q  <= '0;
      mode_q <= MODE_HBLANK;
      line_q <= '0;
      coin_q <= 1'b0;
      win_q  <= 1'b0;
    end else if (step_i) begin
      dot_q  <= dot_d;
      mode_q <= mode_d;
      line_q <= line_d;
      coin_q <= coin_d;
      win_q  <= win_d;
    end
  end

  always_comb begin
    result_o              = '0;
    result_o.mode         = mode_d;
    result_o.line         = line_d;
    result_o.coincidence  = coin_d;
    result_o.lcd_irq      = lcd_irq;
    result_o.vblank_irq   = vblank_irq;
    result_o.render_line  = render;
    result_o.window_armed = win_d;
  end

  a_lcd_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !cfg_i.lcd_enable) |=> (line_q == '0 && dot_q == '0 && mode_q == MODE_OAM))
    else $error("lcd off did not clear line and dot counters");

  a_no_tick_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && cfg_i.lcd_enable && !tick_i) |=> ($stable(line_q) && $stable(dot_q)))
    else $error("state moved without a dot tick");

  a_line_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_q <= LAST_LINE) && (dot_q < LINE_DOTS))
    else $error("line or dot counter out of range");

  a_vblank_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.vblank_irq) |=> (mode_q == MODE_VBLANK && !win_q))
    else $error("vblank pulse without entering vblank");

endmodule

[src/lcdt_out_skid.sv]
module lcdt_out_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              ready_o,
  input  lcdt_pkg::result_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output lcdt_pkg::result_t data_o
);
  import lcdt_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_free;

  assign out_free = ready_i || !out_valid_q;
  assign ready_o  = !skid_valid_q;
  assign valid_o  = out_valid_q;
  assign data_o   = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      // drain the skid word first, otherwise load straight from the input
      out_valid_d  = skid_valid_q || push_i;
      out_d        = skid_valid_q ? skid_q : data_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  a_skid_fills_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && !ready_i) |=> skid_valid_q)
    else $error("word accepted during stall was not parked");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("push while skid stage full");

endmodule

[src/lcd_mode_timing_controller_unit.sv]
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[0] tick, [7:1] zero
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: mode, line, coincidence, irqs, ...
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i register, cfg_data_i value
//
// One result word per input word: the dot step is computed between the
// timing state registers and the output register.
// A new word is taken every cycle; the output register plus a skid word
// absorb a stalled consumer, and s_axis_tready drops only when both are full.
// Reset clears the timing state, the output handshake, and loads register
// defaults (LCD on, everything else off). cfg_ready_o is always high.
module lcd_mode_timing_controller_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata[0] tick, [7:1] zero
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lcdt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tdata[1:0] mode, [9:2] line, [10] coincidence, [11] lcd_irq,
  // [12] vblank_irq, [13] render_line, [14] window_armed, [15] zero
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lcdt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lcdt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lcdt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lcdt_pkg::*;

  cfg_t    cfg;
  result_t step_res;
  result_t out_res;
  logic    in_ready;
  logic    push;

  // advance the timing only on an accepted word
  assign push          = s_axis_tvalid && in_ready;
  assign s_axis_tready = in_ready;
  assign m_axis_tdata  = out_res;

  lcdt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lcdt_timing u_timing (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (push),
    .tick_i   (s_axis_tdata[0]),
    .cfg_i    (cfg),
    .result_o (step_res)
  );

  lcdt_out_skid u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (in_ready),
    .data_i  (step_res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_res)
  );

endmodule

[tb/sv/testbench.sv]
module testbench;
  import lcdt_pkg::*;

  // Generous ceiling for about a thousand words with idle bursts and drains.
  localparam int unsigned CYCLE_LIMIT = 200_000;

  // Predicts the status word for every accepted dot word and compares it with
  // what the block delivers, oldest first.
  class lcd_timing_board;
    cfg_t       cfg;
    logic [8:0] dots;
    mode_e      mode;
    logic [7:0] line_no;
    bit         coinc;
    bit         win_armed;
    result_t    expected_status[$];
    int         errors;

    function new();
      cfg = '0;
      cfg.lcd_enable = 1'b1;
      dots = '0;
      mode = MODE_HBLANK;
      line_no = '0;
      coinc = 1'b0;
      win_armed = 1'b0;
      errors = 0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [7:0] v);
      case (idx)
        REG_LCD_ENABLE:     cfg.lcd_enable = v[0];
        REG_WIN_ENABLE:     cfg.win_enable = v[0];
        REG_WINDOW_LINE:    cfg.window_line = v;
        REG_COMPARE_LINE:   cfg.compare_line = v;
        REG_HBLANK_IRQ_EN:  cfg.hblank_irq_en = v[0];
        REG_VBLANK_IRQ_EN:  cfg.vblank_irq_en = v[0];
        REG_OAM_IRQ_EN:     cfg.oam_irq_en = v[0];
        REG_COMPARE_IRQ_EN: cfg.compare_irq_en = v[0];
        default: ;
      endcase
    endfunction

    // Refresh the coincidence flag on a line change; true when it asks for an LCD irq.
    function bit line_compare();
      coinc = (line_no == cfg.compare_line);
      return coinc && cfg.compare_irq_en;
    endfunction

    function void dot_accepted(bit tick);
      result_t r;
      bit      lcd_irq;
      bit      vb_irq;
      bit      render;
      lcd_irq = 1'b0;
      vb_irq = 1'b0;
      render = 1'b0;
      if (!cfg.lcd_enable) begin
        line_no = '0;
        dots = '0;
        mode = MODE_OAM;
      end else if (tick) begin
        dots = dots + 9'd1;
        case (mode)
          MODE_OAM: begin
            if (dots >= DOTS_OAM) begin
              dots = dots - DOTS_OAM;
              mode = MODE_DRAW;
            end
          end
          MODE_DRAW: begin
            if (dots >= DOTS_DRAW) begin
              dots = dots - DOTS_DRAW;
              mode = MODE_HBLANK;
              lcd_irq |= cfg.hblank_irq_en;
              render = (line_no <= LAST_VISIBLE_LINE);
            end
          end
          MODE_HBLANK: begin
            if (dots >= DOTS_HBLANK) begin
              dots = dots - DOTS_HBLANK;
              if (line_no != LAST_VISIBLE_LINE) begin
                mode = MODE_OAM;
                lcd_irq |= cfg.oam_irq_en;
                // next line is compared at 9 bits, so line 255 never arms line 0
                if (cfg.win_enable && ({1'b0, line_no} + 9'd1) == {1'b0, cfg.window_line})
                  win_armed = 1'b1;
              end else begin
                mode = MODE_VBLANK;
                lcd_irq |= cfg.vblank_irq_en;
                vb_irq = 1'b1;
                win_armed = 1'b0;
              end
              line_no = line_no + 8'd1;
              lcd_irq |= line_compare();
            end
          end
          default: begin
            if (dots >= LINE_DOTS) begin
              dots = dots - LINE_DOTS;
              if (line_no == LAST_LINE) begin
                line_no = '0;
                mode = MODE_OAM;
                lcd_irq |= cfg.oam_irq_en;
              end else begin
                line_no = line_no + 8'd1;
              end
              lcd_irq |= line_compare();
            end
          end
        endcase
      end
      r = '0;
      r.mode = mode;
      r.line = line_no;
      r.coincidence = coinc;
      r.lcd_irq = lcd_irq;
      r.vblank_irq = vb_irq;
      r.render_line = render;
      r.window_armed = win_armed;
      expected_status.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] word);
      result_t got;
      result_t want;
      got = result_t'(word);
      if (expected_status.size() == 0) begin
        errors++;
        $error("status word 0x%04h arrived with nothing expected", word);
        return;
      end
      want = expected_status.pop_front();
      compare_field("mode", want.mode, got.mode);
      compare_field("line", want.line, got.line);
      compare_field("coincidence", want.coincidence, got.coincidence);
      compare_field("lcd_irq", want.lcd_irq, got.lcd_irq);
      compare_field("vblank_irq", want.vblank_irq, got.vblank_irq);
      compare_field("render_line", want.render_line, got.render_line);
      compare_field("window_armed", want.window_armed, got.window_armed);
      compare_field("pad", 0, got.pad);
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;    // [0] tick, [7:1] zero
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;         // mode, line, coincidence, irqs, render, window
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  lcd_timing_board board = new();

  // Idle bursts on both sides: one burst roughly every gap_odds words.
  bit          gaps_on = 1'b1;
  int unsigned gap_odds = 4;
  int unsigned words_seen = 0;
  int unsigned cycles = 0;

  lcd_mode_timing_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Offer one dot word and hold it until the block takes it, then maybe go quiet.
  task automatic push_dot(bit tick);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_DATA_W-1){1'b0}}, tick};
    do @(posedge clk_i); while (!s_axis_tready);
    board.dot_accepted(tick);
    if (gaps_on && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Write one register, then leave the channel idle.
  task automatic write_register(cfg_reg_e idx, logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_register(idx, v);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every predicted word to come back, then leave the bus idle as slack.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Consumer: check every accepted word, stall in bursts, and once hold off long
  // enough for the output and skid registers to fill and back up the input.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    bit          held_once;
    stall_left = 0;
    hold_left = 0;
    held_once = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_word(m_axis_tdata);
        words_seen++;
      end
      if (!held_once && words_seen >= 600) begin
        held_once = 1'b1;
        hold_left = 80;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(1, gap_odds) == 1) begin
        stall_left = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] v;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle dots leave the reset state alone, then a few real dots.
    repeat (3) push_dot(1'b0);
    repeat (5) push_dot(1'b1);
    push_dot(1'b0);
    drain();

    // LCD off forces line 0 and oam scan whatever the tick says.
    write_register(REG_LCD_ENABLE, 8'd0);
    push_dot(1'b1);
    push_dot(1'b0);
    push_dot(1'b1);
    drain();
    write_register(REG_LCD_ENABLE, 8'd1);
    push_dot(1'b0);
    repeat (6) push_dot(1'b1);
    drain();

    // Random segments with fresh settings in between; small line numbers so that
    // compare and window hits land within the few lines the run covers.
    for (int seg = 0; seg < 8; seg++) begin
      write_register(REG_LCD_ENABLE, 8'($urandom_range(0, 4) != 0));
      if ($urandom_range(0, 1)) write_register(REG_WIN_ENABLE, 8'($urandom_range(0, 1)));
      case ($urandom_range(0, 3))
        0:       v = 8'd0;
        1:       v = 8'hFF;
        default: v = 8'($urandom_range(1, 3));
      endcase
      write_register(REG_WINDOW_LINE, v);
      case ($urandom_range(0, 3))
        0:       v = 8'd0;
        1:       v = 8'hFF;
        default: v = 8'($urandom_range(0, 3));
      endcase
      write_register(REG_COMPARE_LINE, v);
      write_register(REG_HBLANK_IRQ_EN, 8'($urandom_range(0, 1)));
      write_register(REG_VBLANK_IRQ_EN, 8'($urandom_range(0, 1)));
      write_register(REG_OAM_IRQ_EN, 8'($urandom_range(0, 1)));
      write_register(REG_COMPARE_IRQ_EN, 8'($urandom_range(0, 1)));
      gaps_on = (seg != 3);
      gap_odds = 4;
      repeat (92) push_dot($urandom_range(0, 7) != 0);
      drain();
    end

    // Closing stretch at full rate, no idling on either side.
    gaps_on = 1'b0;
    repeat (200) push_dot($urandom_range(0, 3) != 0);
    drain();
    repeat (8) @(posedge clk_i);

    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
